// ----- rtl/vce_pkg.sv -----
// shared types, constants and codes for the verdict cache
`timescale 1ns / 1ps
`default_nettype none
package vce_pkg;

  localparam int ENTRIES   = 256;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int KEY_BYTES = 36;
  localparam int RAW_BYTES = 36;
  localparam int KEY_BITS  = RAW_BYTES * 8;
  localparam int HASH_W    = 32;
  localparam int TICK_W    = 32;
  localparam int LIFE_W    = 31;
  localparam int RES_W     = 2;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(300000);

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [RES_W-1:0] RES_MISS    = 2'd0;
  localparam logic [RES_W-1:0] RES_VALID   = 2'd1;
  localparam logic [RES_W-1:0] RES_INVALID = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic                verdict;
    logic [TICK_W-1:0]   now;
  } query_t;

  typedef struct packed {
    logic              live;
    logic              found;
    logic              verdict;
    logic [TICK_W-1:0] stamp;
    logic [IDX_W-1:0]  idx;
  } tok_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/vce_key_form.sv -----
// identifier normalisation: cut at the first zero byte and at the key length
`timescale 1ns / 1ps
`default_nettype none
module vce_key_form (
  input  wire logic [vce_pkg::KEY_BITS-1:0] raw,
  output logic      [vce_pkg::KEY_BITS-1:0] key
);

  logic [vce_pkg::RAW_BYTES-1:0] nz;
  logic [vce_pkg::RAW_BYTES-1:0] keep;

  always_comb begin
    for (int i = 0; i < vce_pkg::RAW_BYTES; i++) begin
      nz[i] = (|raw[8*i +: 8]) && (i < vce_pkg::KEY_BYTES);
    end
    for (int i = 0; i < vce_pkg::RAW_BYTES; i++) begin
      keep[i] = &(nz | ({vce_pkg::RAW_BYTES{1'b1}} << (i + 1)));
    end
    for (int i = 0; i < vce_pkg::RAW_BYTES; i++) begin
      key[8*i +: 8] = keep[i] ? raw[8*i +: 8] : 8'h00;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vce_cell.sv -----
// one cache entry with its compare stage in the scan chain
`timescale 1ns / 1ps
`default_nettype none
module vce_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [vce_pkg::IDX_W-1:0] idx,
  input  wire vce_pkg::cell_ctl_t       ctl,
  input  wire vce_pkg::query_t          query,
  input  wire logic                     query_zero,
  input  wire vce_pkg::tok_t            tok_in,
  output vce_pkg::tok_t                 tok_out
);

  logic                          valid;
  logic [vce_pkg::KEY_BITS-1:0]  key;
  logic [vce_pkg::HASH_W-1:0]    hash;
  logic                          verdict;
  logic [vce_pkg::TICK_W-1:0]    stamp;

  logic          match;
  logic          hit;
  vce_pkg::tok_t tok_next;

  always_comb begin
    if (valid) begin
      match = (key == query.key) && (hash == query.hash);
    end else begin
      match = query_zero;
    end
    hit = tok_in.live && !tok_in.found && match;
    tok_next = tok_in;
    if (hit) begin
      tok_next.found   = 1'b1;
      tok_next.verdict = valid & verdict;
      tok_next.stamp   = valid ? stamp : '0;
      tok_next.idx     = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.wr) begin
      valid <= 1'b1;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key     <= query.key;
      hash    <= query.hash;
      verdict <= query.verdict;
      stamp   <= query.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/verdict_cache_with_expiry.sv -----
// verdict cache top level: request capture, scan chain of entries, expiry and response
//
//   channel   signals                       transaction
//   req       req_valid / req_ready         one lookup or insert
//   rsp       rsp_valid / rsp_ready         one lookup_result per lookup
//   cfg       cfg_wr_en / cfg_wr_data       lifetime_ticks write, no wait
//
// a lookup runs from acceptance through the launch register, the chain and the hold register
// to the response: a token walks the chain of ENTRIES cells, one cell a cycle, and the first
// matching cell tags it; an insert goes through the write state and gives no response
// reset clears every entry at once through the per-cell valid flags
// a pending response holds the block after the scan until rsp_ready is seen
`timescale 1ns / 1ps
`default_nettype none
module verdict_cache_with_expiry (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic                       func,
  input  wire logic [63:0]                key_word_a,
  input  wire logic [63:0]                key_word_b,
  input  wire logic [63:0]                key_word_c,
  input  wire logic [63:0]                key_word_d,
  input  wire logic [31:0]                key_word_e,
  input  wire logic [vce_pkg::HASH_W-1:0] key_hash,
  input  wire logic                       verdict,
  input  wire logic [vce_pkg::TICK_W-1:0] now_ticks,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic [vce_pkg::RES_W-1:0]       lookup_result,
  input  wire logic                       cfg_wr_en,
  input  wire logic [vce_pkg::LIFE_W-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [vce_pkg::LIFE_W-1:0]    lifetime;
  logic [vce_pkg::IDX_W-1:0]     counter;
  logic [vce_pkg::IDX_W-1:0]     counter_next;
  logic                          launch;
  vce_pkg::query_t               query;
  vce_pkg::tok_t                 hold;

  logic [vce_pkg::KEY_BITS-1:0]  formed_key;
  logic                          accept;
  logic                          query_zero;
  logic                          wr_pulse;
  logic                          clr_pulse;
  logic                          rsp_load;
  logic [vce_pkg::TICK_W-1:0]    age_diff;
  logic                          entry_live;
  vce_pkg::tok_t                 chain_head;

  vce_pkg::tok_t                 chain [vce_pkg::ENTRIES+1];
  vce_pkg::cell_ctl_t            ctl   [vce_pkg::ENTRIES];

  vce_key_form u_key_form (
    .raw ({key_word_e, key_word_d, key_word_c, key_word_b, key_word_a}),
    .key (formed_key)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign query_zero = ~|query.key && ~|query.hash;

  assign counter_next = (counter == vce_pkg::IDX_W'(vce_pkg::ENTRIES - 1)) ?
                        '0 : counter + 1'b1;

  assign age_diff   = query.now - hold.stamp - {1'b0, lifetime};
  assign entry_live = age_diff[vce_pkg::TICK_W-1];
  assign rsp_load   = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  assign wr_pulse   = (state == ST_WRITE);
  assign clr_pulse  = rsp_load && hold.found && !entry_live;

  always_comb begin
    chain_head      = '0;
    chain_head.live = launch;
  end

  assign chain[0] = chain_head;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func == vce_pkg::FUNC_INSERT) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_SCAN: begin
        if (chain[vce_pkg::ENTRIES].live) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      counter  <= '0;
      launch   <= 1'b0;
      lifetime <= vce_pkg::LIFETIME_RESET;
    end else begin
      state  <= state_next;
      launch <= accept && (func == vce_pkg::FUNC_LOOKUP);
      if (accept && (func == vce_pkg::FUNC_INSERT)) begin
        counter <= counter_next;
      end
      if (cfg_wr_en) begin
        lifetime <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query.key     <= formed_key;
      query.hash    <= key_hash;
      query.verdict <= verdict;
      query.now     <= now_ticks;
    end
    if (state == ST_SCAN && chain[vce_pkg::ENTRIES].live) begin
      hold <= chain[vce_pkg::ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (hold.found && entry_live) begin
        lookup_result <= hold.verdict ? vce_pkg::RES_VALID : vce_pkg::RES_INVALID;
      end else begin
        lookup_result <= vce_pkg::RES_MISS;
      end
    end
  end

  for (genvar i = 0; i < vce_pkg::ENTRIES; i++) begin : g_cell
    assign ctl[i].wr  = wr_pulse && (counter == vce_pkg::IDX_W'(i));
    assign ctl[i].clr = clr_pulse && (hold.idx == vce_pkg::IDX_W'(i));

    vce_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (vce_pkg::IDX_W'(i)),
      .ctl        (ctl[i]),
      .query      (query),
      .query_zero (query_zero),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

endmodule
`default_nettype wire
